@@ rtl/cia_pkg.sv @@
// package: opcodes, status codes and shared types for the checked integer alu
package cia_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FUNC_W    = 5;
    localparam int STAT_W    = 3;
    localparam int RES_W     = 64;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD = 5'd0, F_SUB = 5'd1, F_MUL = 5'd2, F_DIV = 5'd3, F_MOD = 5'd4,
        F_NEG = 5'd5, F_NOT = 5'd6, F_AND = 5'd7, F_OR = 5'd8, F_XOR = 5'd9,
        F_SHL = 5'd10, F_SHR = 5'd11, F_EQ = 5'd12, F_NE = 5'd13, F_LT = 5'd14,
        F_LE = 5'd15, F_GT = 5'd16, F_GE = 5'd17, F_CVT = 5'd18
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK = 3'd0, ST_OVER = 3'd1, ST_UNDER = 3'd2, ST_DIVZ = 3'd3, ST_SHIFT = 3'd4
    } t_status;

    typedef struct packed {
        logic    done;
        logic    fixed;
        logic    is_mod;
        logic    sg;
        logic    neg_q;
        logic    neg_r;
        logic    [RES_W-1:0] res;
        t_status st;
    } t_ctl;

endpackage

@@ rtl/cia_div_cell.sv @@
// one restoring divider stage, one quotient bit per cell
module cia_div_cell #(
    parameter int WIDTH = cia_pkg::WIDTH_DEF,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    input  cia_pkg::t_ctl    i_ctl,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_num,
    output logic [WIDTH-1:0] o_den,
    output cia_pkg::t_ctl    o_ctl
);
    import cia_pkg::*;

    logic [WIDTH:0]   n_trial;
    logic [WIDTH:0]   n_diff;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_num;
    logic             r_vld;
    logic [WIDTH-1:0] r_rem, r_num, r_den;
    t_ctl             r_ctl;

    always_comb begin
        n_trial = {i_rem, i_num[WIDTH-1-IDX]};
        n_diff  = n_trial - {1'b0, i_den};
        n_num   = i_num;
        if (!n_diff[WIDTH]) begin
            n_rem = n_diff[WIDTH-1:0];
            n_num[WIDTH-1-IDX] = 1'b1;
        end else begin
            n_rem = n_trial[WIDTH-1:0];
            n_num[WIDTH-1-IDX] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
            r_ctl <= i_ctl;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_ctl = r_ctl;
endmodule

@@ rtl/cia_front.sv @@
// first stage: decode, checks, simple ops, operand magnitudes and product
module cia_front #(
    parameter int WIDTH = cia_pkg::WIDTH_DEF
) (
    input  logic                  i_sg,
    input  logic [cia_pkg::FUNC_W-1:0] i_func,
    input  logic [WIDTH-1:0]      i_a,
    input  logic [WIDTH-1:0]      i_b,
    input  logic [7:0]            i_sh,
    input  logic [1:0]            i_twc,
    input  logic                  i_tsig,
    output logic [WIDTH-1:0]      o_num,
    output logic [WIDTH-1:0]      o_den,
    output logic [2*WIDTH-1:0]    o_prod,
    output cia_pkg::t_ctl         o_ctl
);
    import cia_pkg::*;

    localparam logic [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};

    logic             a_neg, b_neg;
    logic [WIDTH-1:0] mag_a, mag_b;
    logic [WIDTH:0]   sum, dif;
    logic [WIDTH-1:0] shr_v;
    logic [WIDTH-1:0] neg_v, not_v, shl_v;
    logic             lt_v, eq_v;
    logic [RES_W-1:0] ext_a, tmask;
    logic [RES_W-1:0] tmax;
    logic             in_lo, big;

    always_comb begin
        a_neg = i_sg & i_a[WIDTH-1];
        b_neg = i_sg & i_b[WIDTH-1];
        mag_a = a_neg ? (~i_a + 1'b1) : i_a;
        mag_b = b_neg ? (~i_b + 1'b1) : i_b;
        o_prod = mag_a * mag_b;
        sum = {a_neg, i_a} + {b_neg, i_b};
        dif = {a_neg, i_a} - {b_neg, i_b};
        shr_v = WIDTH'($signed({a_neg, i_a}) >>> i_sh);
        neg_v = ~i_a + 1'b1;
        not_v = ~i_a;
        shl_v = i_a << i_sh;
        eq_v = (i_a == i_b);
        lt_v = i_sg ? ($signed(i_a) < $signed(i_b)) : (i_a < i_b);
        ext_a = a_neg ? {{(RES_W-WIDTH){1'b1}}, i_a} : {{(RES_W-WIDTH){1'b0}}, i_a};
        case (i_twc)
            2'd0:    tmask = 64'h0000_0000_0000_00ff;
            2'd1:    tmask = 64'h0000_0000_0000_ffff;
            2'd2:    tmask = 64'h0000_0000_ffff_ffff;
            default: tmask = '1;
        endcase
        tmax  = i_tsig ? (tmask >> 1) : tmask;
        big   = (ext_a > tmax);
        // negative value fits when its bits from the target sign bit up are all ones
        in_lo = ((ext_a | (tmask >> 1)) == '1);

        o_num = mag_a;
        o_den = mag_b;
        o_ctl = '0;
        o_ctl.done   = 1'b1;
        o_ctl.sg     = i_sg;
        o_ctl.neg_q  = a_neg ^ b_neg;
        o_ctl.neg_r  = a_neg;
        o_ctl.is_mod = (i_func == F_MOD);
        o_ctl.st     = ST_OK;
        case (i_func)
            F_ADD: begin
                if (i_sg) begin
                    if (sum[WIDTH] != sum[WIDTH-1])
                        o_ctl.st = sum[WIDTH] ? ST_UNDER : ST_OVER;
                end else if (sum[WIDTH]) o_ctl.st = ST_OVER;
                o_ctl.res = RES_W'(sum[WIDTH-1:0]);
            end
            F_SUB: begin
                if (i_sg) begin
                    if (dif[WIDTH] != dif[WIDTH-1])
                        o_ctl.st = dif[WIDTH] ? ST_UNDER : ST_OVER;
                end else if (dif[WIDTH]) o_ctl.st = ST_UNDER;
                o_ctl.res = RES_W'(dif[WIDTH-1:0]);
            end
            F_MUL: begin
                o_ctl.done = 1'b0;
                o_ctl.fixed = 1'b1;
            end
            F_DIV, F_MOD: begin
                if (i_b == '0) o_ctl.st = ST_DIVZ;
                else if (i_sg && i_a == SMIN && i_b == '1) o_ctl.st = ST_OVER;
                else o_ctl.done = 1'b0;
            end
            F_NEG: begin
                if (i_sg) begin
                    if (i_a == SMIN) o_ctl.st = ST_OVER;
                    else o_ctl.res = RES_W'(neg_v);
                end else if (i_a != '0) o_ctl.st = ST_UNDER;
            end
            F_NOT: o_ctl.res = RES_W'(not_v);
            F_AND: o_ctl.res = RES_W'(i_a & i_b);
            F_OR:  o_ctl.res = RES_W'(i_a | i_b);
            F_XOR: o_ctl.res = RES_W'(i_a ^ i_b);
            F_SHL: begin
                if (i_sh >= 8'(WIDTH)) o_ctl.st = ST_SHIFT;
                else o_ctl.res = RES_W'(shl_v);
            end
            F_SHR: begin
                if (i_sh >= 8'(WIDTH)) o_ctl.st = ST_SHIFT;
                else o_ctl.res = RES_W'(shr_v);
            end
            F_EQ: o_ctl.res = RES_W'(eq_v);
            F_NE: o_ctl.res = RES_W'(!eq_v);
            F_LT: o_ctl.res = RES_W'(lt_v);
            F_LE: o_ctl.res = RES_W'(lt_v | eq_v);
            F_GT: o_ctl.res = RES_W'(!(lt_v | eq_v));
            F_GE: o_ctl.res = RES_W'(!lt_v);
            F_CVT: begin
                if (a_neg) begin
                    if (!i_tsig || !in_lo) o_ctl.st = ST_UNDER;
                    else o_ctl.res = ext_a & tmask;
                end else if (big) o_ctl.st = ST_OVER;
                else o_ctl.res = ext_a & tmask;
            end
            default: o_ctl.res = '0;
        endcase
        if (o_ctl.st != ST_OK) o_ctl.res = '0;
    end
endmodule

@@ rtl/cia_back.sv @@
// last stage: product range check and quotient or remainder sign fixup
module cia_back #(
    parameter int WIDTH = cia_pkg::WIDTH_DEF
) (
    input  logic [WIDTH-1:0]   i_quo,
    input  logic [WIDTH-1:0]   i_rem,
    input  logic [2*WIDTH-1:0] i_prod,
    input  cia_pkg::t_ctl      i_ctl,
    output logic [cia_pkg::RES_W-1:0] o_res,
    output logic [cia_pkg::STAT_W-1:0] o_st
);
    import cia_pkg::*;

    logic [2*WIDTH-1:0] lim;
    logic [WIDTH-1:0]   v, sv;
    t_status            st;

    always_comb begin
        st = i_ctl.st;
        o_res = i_ctl.res;
        lim = '0;
        sv = '0;
        v = '0;
        if (!i_ctl.done && i_ctl.fixed) begin
            // positive limit is max, negative limit is magnitude of min
            if (!i_ctl.sg) lim = (2*WIDTH)'({WIDTH{1'b1}});
            else if (i_ctl.neg_q) lim = (2*WIDTH)'({1'b1, {(WIDTH-1){1'b0}}});
            else lim = (2*WIDTH)'({1'b0, {(WIDTH-1){1'b1}}});
            sv = i_prod[WIDTH-1:0];
            v = (i_ctl.sg && i_ctl.neg_q) ? (~sv + 1'b1) : sv;
            if (i_prod > lim) begin
                st = (i_ctl.sg && i_ctl.neg_q) ? ST_UNDER : ST_OVER;
                o_res = '0;
            end else o_res = RES_W'(v);
        end else if (!i_ctl.done) begin
            if (i_ctl.is_mod) v = i_ctl.neg_r ? (~i_rem + 1'b1) : i_rem;
            else v = i_ctl.neg_q ? (~i_quo + 1'b1) : i_quo;
            o_res = RES_W'(v);
        end
        o_st = st;
    end
endmodule

@@ rtl/checked_integer_alu.sv @@
// top level: checked integer alu with a chain of divider cells
// Each request passes through one decode and multiply stage, a chain of WIDTH
// divider cells that each settle one quotient bit, and one output register. A
// new request is accepted every cycle unless the result is stalled; the whole
// chain advances together and holds while the result is stalled.
module checked_integer_alu #(
    parameter int WIDTH = cia_pkg::WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [cia_pkg::FUNC_W-1:0] i_func,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [7:0]  i_shift_amount,
    input  logic [1:0]  i_target_width_code,
    input  logic        i_target_signed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [cia_pkg::RES_W-1:0] o_result_bits,
    output logic [cia_pkg::STAT_W-1:0] o_status
);
    import cia_pkg::*;

    logic r_sg;
    logic adv;

    logic [WIDTH-1:0]   f_num, f_den;
    logic [2*WIDTH-1:0] f_prod;
    t_ctl               f_ctl;

    logic               r_v0;
    logic [WIDTH-1:0]   r_num0, r_den0;
    t_ctl               r_ctl0;
    logic [2*WIDTH-1:0] r_prod [WIDTH+1];

    logic               c_vld [WIDTH+1];
    logic [WIDTH-1:0]   c_rem [WIDTH+1];
    logic [WIDTH-1:0]   c_num [WIDTH+1];
    logic [WIDTH-1:0]   c_den [WIDTH+1];
    t_ctl               c_ctl [WIDTH+1];

    logic [RES_W-1:0]   b_res;
    logic [STAT_W-1:0]  b_st;
    logic               r_ov;
    logic [RES_W-1:0]   r_res;
    logic [STAT_W-1:0]  r_st;

    assign adv     = !(r_ov && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg <= 1'b1;
        end else if (i_cfg_we) begin
            r_sg <= i_cfg_wdata;
        end
    end

    cia_front #(.WIDTH(WIDTH)) u_front (
        .i_sg(r_sg), .i_func(i_func),
        .i_a(i_operand_a[WIDTH-1:0]), .i_b(i_operand_b[WIDTH-1:0]),
        .i_sh(i_shift_amount), .i_twc(i_target_width_code), .i_tsig(i_target_signed),
        .o_num(f_num), .o_den(f_den), .o_prod(f_prod), .o_ctl(f_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num0    <= f_num;
            r_den0    <= f_den;
            r_ctl0    <= f_ctl;
            r_prod[0] <= f_prod;
            for (int k = 1; k <= WIDTH; k++) r_prod[k] <= r_prod[k-1];
        end
    end

    assign c_vld[0] = r_v0;
    assign c_rem[0] = '0;
    assign c_num[0] = r_num0;
    assign c_den[0] = r_den0;
    assign c_ctl[0] = r_ctl0;

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        cia_div_cell #(.WIDTH(WIDTH), .IDX(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
            .i_vld(c_vld[g]), .i_rem(c_rem[g]), .i_num(c_num[g]),
            .i_den(c_den[g]), .i_ctl(c_ctl[g]),
            .o_vld(c_vld[g+1]), .o_rem(c_rem[g+1]), .o_num(c_num[g+1]),
            .o_den(c_den[g+1]), .o_ctl(c_ctl[g+1])
        );
    end

    cia_back #(.WIDTH(WIDTH)) u_back (
        .i_quo(c_num[WIDTH]), .i_rem(c_rem[WIDTH]), .i_prod(r_prod[WIDTH]),
        .i_ctl(c_ctl[WIDTH]), .o_res(b_res), .o_st(b_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= c_vld[WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= b_res;
            r_st  <= b_st;
        end
    end

    assign o_valid       = r_ov;
    assign o_result_bits = r_res;
    assign o_status      = r_st;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_result_bits == '0)
        else $error("error result not zero");
    a_stat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_SHIFT)
        else $error("status code out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");
endmodule

@@ verif/checked_integer_alu_tb.sv @@
// testbench for the checked integer alu: queued random and directed requests, scoreboard check
module checked_integer_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cia_pkg::*;

    localparam int W = 32;
    localparam logic [63:0] WMASK = (64'd1 << W) - 64'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [7:0]        sh;
        logic [1:0]        twc;
        logic              tsig;
    } t_req;

    typedef struct packed {
        logic [63:0]       res;
        logic [STAT_W-1:0] st;
    } t_resp;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [FUNC_W-1:0] func = '0;
    logic [31:0] opa = '0, opb = '0;
    logic [7:0] shamt = '0;
    logic [1:0] twc = '0;
    logic tsig = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [RES_W-1:0] res_bits;
    logic [STAT_W-1:0] status;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    logic  signed_mode = 1'b1;
    int    errors = 0;
    int    reqs_sent = 0;
    int    resps_seen = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    logic  hold_off = 1'b0;
    int    stall_phase = 0;

    checked_integer_alu dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall), .i_func(func),
        .i_operand_a(opa), .i_operand_b(opb), .i_shift_amount(shamt),
        .i_target_width_code(twc), .i_target_signed(tsig),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_result_bits(res_bits), .o_status(status)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic t_resp alu_compute(t_req r, logic sg);
        logic [63:0] ua, ub, res, tmask, tmaxu;
        longint sa, sb, smax, smin, tmin, prod;
        logic [2:0] st;
        int tw;
        ua = {32'd0, r.a} & WMASK;
        ub = {32'd0, r.b} & WMASK;
        sa = longint'($signed(r.a[W-1:0]));
        sb = longint'($signed(r.b[W-1:0]));
        smax = longint'(WMASK >> 1);
        smin = -smax - 1;
        res = '0;
        st = ST_OK;
        case (r.func)
            F_ADD, F_SUB, F_MUL: begin
                if (sg) begin
                    if (r.func == F_ADD) prod = sa + sb;
                    else if (r.func == F_SUB) prod = sa - sb;
                    else prod = sa * sb;
                    if (prod > smax) st = ST_OVER;
                    else if (prod < smin) st = ST_UNDER;
                    else res = 64'(prod) & WMASK;
                end else begin
                    if (r.func == F_ADD) res = ua + ub;
                    else if (r.func == F_SUB) res = ua - ub;
                    else res = ua * ub;
                    if (r.func == F_SUB && ua < ub) st = ST_UNDER;
                    else if (r.func != F_SUB && res > WMASK) st = ST_OVER;
                end
            end
            F_DIV, F_MOD: begin
                if (ub == 0) st = ST_DIVZ;
                else if (sg) begin
                    if (sa == smin && sb == -1) st = ST_OVER;
                    else res = 64'(r.func == F_DIV ? sa / sb : sa % sb) & WMASK;
                end else res = r.func == F_DIV ? ua / ub : ua % ub;
            end
            F_NEG: begin
                if (sg) begin
                    if (sa == smin) st = ST_OVER;
                    else res = 64'(-sa) & WMASK;
                end else if (ua != 0) st = ST_UNDER;
            end
            F_NOT: res = ~ua & WMASK;
            F_AND: res = ua & ub;
            F_OR:  res = ua | ub;
            F_XOR: res = ua ^ ub;
            F_SHL: begin
                if (r.sh >= W) st = ST_SHIFT;
                else res = (ua << r.sh) & WMASK;
            end
            F_SHR: begin
                if (r.sh >= W) st = ST_SHIFT;
                else if (sg) res = 64'(sa >>> r.sh) & WMASK;
                else res = ua >> r.sh;
            end
            F_EQ: res = 64'(ua == ub);
            F_NE: res = 64'(ua != ub);
            F_LT: res = 64'(sg ? sa < sb : ua < ub);
            F_LE: res = 64'(sg ? sa <= sb : ua <= ub);
            F_GT: res = 64'(sg ? sa > sb : ua > ub);
            F_GE: res = 64'(sg ? sa >= sb : ua >= ub);
            F_CVT: begin
                tw = 8 << r.twc;
                tmask = (tw == 64) ? '1 : ((64'd1 << tw) - 64'd1);
                tmaxu = r.tsig ? (tmask >> 1) : tmask;
                if (sg && sa < 0) begin
                    tmin = -longint'(tmask >> 1) - 1;
                    if (!r.tsig || sa < tmin) st = ST_UNDER;
                    else res = 64'(sa) & tmask;
                end else if (ua > tmaxu) st = ST_OVER;
                else res = ua & tmask;
            end
            default: ;
        endcase
        if (st != ST_OK) res = '0;
        return '{res: res, st: st};
    endfunction

    // driver
    always @(posedge clk) begin
        t_req r;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_resps.push_back(alu_compute(pending_reqs.pop_front(), signed_mode));
                reqs_sent++;
            end
            if (in_valid && in_stall) begin
            end else if (pending_reqs.size() > 0 && !hold_off && gap_left == 0) begin
                r = pending_reqs[0];
                in_valid <= 1'b1;
                func <= r.func; opa <= r.a; opb <= r.b;
                shamt <= r.sh; twc <= r.twc; tsig <= r.tsig;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else burst_left--;
            end else begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk) begin
        t_resp e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                resps_seen++;
                if (expected_resps.size() == 0) begin
                    $error("unexpected result res=%h status=%0d", res_bits, status);
                    errors++;
                end else begin
                    e = expected_resps.pop_front();
                    if (res_bits !== e.res) begin
                        $error("result_bits expected %h actual %h", e.res, res_bits);
                        errors++;
                    end
                    if (status !== e.st) begin
                        $error("status expected %0d actual %0d", e.st, status);
                        errors++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 300;
            if (stall_phase < 60) out_stall <= 1'b0;
            else if (stall_phase < 200) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 300);
            5: return -$urandom_range(1, 300);
            6: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(logic [4:0] f, logic [31:0] a, logic [31:0] b,
                           logic [7:0] s, logic [1:0] w, logic t);
        pending_reqs.push_back('{func: f, a: a, b: b, sh: s, twc: w, tsig: t});
    endtask

    task automatic add_random(int n);
        repeat (n) begin
            add_req(($urandom_range(0, 15) == 0) ? 5'($urandom_range(19, 31))
                                                 : 5'($urandom_range(0, 18)),
                    pick_operand(), pick_operand(),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31)),
                    2'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain_and_set(logic mode);
        wait (pending_reqs.size() == 0);
        hold_off = 1'b1;
        wait (expected_resps.size() == 0 && !in_valid);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        signed_mode = mode;
        hold_off = 1'b0;
    endtask

    initial begin
        int mode_runs;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        add_req(F_ADD, 32'h7fff_ffff, 32'h1, 0, 0, 0);
        add_req(F_ADD, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
        add_req(F_SUB, 32'h8000_0000, 32'h1, 0, 0, 0);
        add_req(F_MUL, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        add_req(F_MUL, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
        add_req(F_MUL, 32'h0, 32'h8000_0000, 0, 0, 0);
        add_req(F_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
        add_req(F_MOD, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
        add_req(F_DIV, 32'd7, 32'h0, 0, 0, 0);
        add_req(F_MOD, 32'hffff_fff9, 32'd2, 0, 0, 0);
        add_req(F_NEG, 32'h8000_0000, 0, 0, 0, 0);
        add_req(F_NOT, 32'h5a5a_a5a5, 0, 0, 0, 0);
        add_req(F_AND, 32'hffff_0000, 32'h0ff0_0ff0, 0, 0, 0);
        add_req(F_OR, 32'hffff_0000, 32'h0ff0_0ff0, 0, 0, 0);
        add_req(F_XOR, 32'hffff_ffff, 32'h1234_5678, 0, 0, 0);
        add_req(F_SHL, 32'hffff_ffff, 0, 8'd31, 0, 0);
        add_req(F_SHR, 32'h8000_0000, 0, 8'd32, 0, 0);
        add_req(F_SHR, 32'h8000_0000, 0, 8'd255, 0, 0);
        add_req(F_LT, 32'hffff_ffff, 32'h1, 0, 0, 0);
        add_req(F_CVT, 32'hffff_ff80, 0, 0, 2'd0, 1'b1);
        add_req(F_CVT, 32'hffff_ff7f, 0, 0, 2'd0, 1'b1);
        add_req(F_CVT, 32'hffff_ffff, 0, 0, 2'd3, 1'b0);
        add_req(F_CVT, 32'h0000_ffff, 0, 0, 2'd1, 1'b0);
        add_req(5'd31, 32'h1, 32'h1, 0, 0, 0);
        add_random(400);
        drain_and_set(1'b0);
        add_req(F_NEG, 32'h1, 0, 0, 0, 0);
        add_req(F_NEG, 32'h0, 0, 0, 0, 0);
        add_req(F_SUB, 32'h0, 32'h1, 0, 0, 0);
        add_req(F_ADD, 32'hffff_ffff, 32'h1, 0, 0, 0);
        add_req(F_CVT, 32'hffff_ffff, 0, 0, 2'd2, 1'b1);
        add_random(400);
        for (mode_runs = 0; mode_runs < 3; mode_runs++) begin
            drain_and_set(mode_runs[0] ? 1'b0 : 1'b1);
            add_random(360);
        end
        wait (pending_reqs.size() == 0 && !in_valid);
        hold_off = 1'b1;
        wait (expected_resps.size() == 0);
        repeat (60) @(posedge clk);
        $display("covered %0d requests and %0d results across signed and unsigned modes",
                 reqs_sent, resps_seen);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
